@@ rtl/adq_pkg.sv @@
// Shared types, codes and widths of the array double-ended queue.
package adq_pkg;

    localparam int ADQ_MAX_SLOTS   = 16;
    localparam int ADQ_DATA_W      = 32;
    localparam int ADQ_CAP_W       = 5;
    localparam int ADQ_OCC_W       = 5;
    localparam int ADQ_OP_W        = 2;
    localparam int ADQ_STAT_W      = 2;
    localparam int ADQ_IN_TDATA_W  = 40;
    localparam int ADQ_OUT_TDATA_W = 40;
    localparam int ADQ_APB_ADDR_W  = 3;
    localparam int ADQ_APB_DATA_W  = 32;

    localparam logic [ADQ_CAP_W-1:0] ADQ_CAP_RESET = 5'd16;

    // Register index of capacity_in_use (word address paddr[2]).
    localparam logic ADQ_REG_CAPACITY = 1'b0;

    typedef enum logic [ADQ_OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } adq_op_t;

    typedef enum logic [ADQ_STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } adq_status_t;

    typedef struct packed {
        adq_status_t            status;
        logic [ADQ_OCC_W-1:0]   occupancy;
        logic                   pop_ok;
    } adq_rslt_t;

endpackage

@@ rtl/adq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module adq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/adq_ctrl.sv @@
// Index and empty-flag bookkeeping of the deque; decides each operation's outcome.
module adq_ctrl #(
    parameter int MAX_SLOTS = adq_pkg::ADQ_MAX_SLOTS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [adq_pkg::ADQ_CAP_W-1:0] cap_cfg,
    input  logic                         accept,
    input  logic [adq_pkg::ADQ_OP_W-1:0] op,
    output logic                         wr_en,
    output logic [$clog2(MAX_SLOTS)-1:0] wr_addr,
    output logic                         rd_en,
    output logic [$clog2(MAX_SLOTS)-1:0] rd_addr,
    output adq_pkg::adq_rslt_t           rslt
);
    import adq_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    // Wide enough for capacity, index + 1 and the occupancy count.
    localparam int CW = (IW + 1 > ADQ_CAP_W) ? IW + 1 : ADQ_CAP_W;
    localparam logic [CW-1:0] MAX_CAP = CW'(MAX_SLOTS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    logic [IW-1:0] front_reg, front_next;
    logic [IW-1:0] rear_reg,  rear_next;
    logic          empty_reg, empty_next;
    logic [CW-1:0] cap_ext, cap_eff, occ_full;
    logic          wr_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (accept) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            empty_reg <= empty_next;
        end
    end

    // A capacity of zero counts as one; above the array size it is clamped.
    always_comb begin
        cap_ext = CW'(cap_cfg);
        if (cap_ext == '0) begin
            cap_eff = ONE;
        end else if (cap_ext > MAX_CAP) begin
            cap_eff = MAX_CAP;
        end else begin
            cap_eff = cap_ext;
        end
    end

    always_comb begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        wr_req      = 1'b0;
        wr_addr     = front_reg;
        rd_addr     = front_reg;
        rslt.status = ST_DONE;
        rslt.pop_ok = 1'b0;

        unique case (adq_op_t'(op))
            OP_PUSH_FRONT: begin
                if (empty_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    wr_req     = 1'b1;
                    wr_addr    = '0;
                end else if (front_reg != '0) begin
                    front_next = front_reg - 1'b1;
                    wr_req     = 1'b1;
                    wr_addr    = front_reg - 1'b1;
                end else begin
                    rslt.status = ST_OVERFLOW;
                end
            end
            OP_PUSH_REAR: begin
                if (empty_reg) begin
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                    wr_req     = 1'b1;
                    wr_addr    = '0;
                end else if (CW'(rear_reg) + ONE >= cap_eff) begin
                    rslt.status = ST_OVERFLOW;
                end else begin
                    rear_next = rear_reg + 1'b1;
                    wr_req    = 1'b1;
                    wr_addr   = rear_reg + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                rd_addr = front_reg;
                if (empty_reg) begin
                    rslt.status = ST_UNDERFLOW;
                end else begin
                    rslt.pop_ok = 1'b1;
                    if (front_reg == rear_reg) begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b1;
                    end else begin
                        front_next = front_reg + 1'b1;
                    end
                end
            end
            OP_POP_REAR: begin
                rd_addr = rear_reg;
                if (empty_reg) begin
                    rslt.status = ST_UNDERFLOW;
                end else begin
                    rslt.pop_ok = 1'b1;
                    if (front_reg == rear_reg) begin
                        front_next = '0;
                        rear_next  = '0;
                        empty_next = 1'b1;
                    end else begin
                        rear_next = rear_reg - 1'b1;
                    end
                end
            end
            default: begin
                rslt.status = ST_DONE;
            end
        endcase

        occ_full       = CW'(rear_next) - CW'(front_next) + ONE;
        rslt.occupancy = empty_next ? '0 : occ_full[ADQ_OCC_W-1:0];
    end

    assign wr_en = accept && wr_req;
    assign rd_en = accept;

endmodule

@@ rtl/array_double_ended_queue.sv @@
// Top level of the array double-ended queue with stream channels and APB configuration.
// After an item is transferred in, its result is held in stage one (index update and
// store read), then in the output register. Throughput: one item per cycle while the
// result channel does not stall; the element store's single read port sets that figure.
// Reset (synchronous, aresetn low) empties the deque, sets capacity to 16 and drops all
// pending results; the element store itself is not cleared.
module array_double_ended_queue #(
    parameter int MAX_SLOTS = adq_pkg::ADQ_MAX_SLOTS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // Input channel. s_tdata: [1:0] operation, [33:2] item_value, [39:34] zero.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [adq_pkg::ADQ_IN_TDATA_W-1:0]   s_tdata,

    // Result channel. m_tdata: [1:0] status, [33:2] removed_item, [38:34] occupancy,
    // [39] zero.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [adq_pkg::ADQ_OUT_TDATA_W-1:0]  m_tdata,

    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [adq_pkg::ADQ_APB_ADDR_W-1:0]   paddr,
    input  logic [adq_pkg::ADQ_APB_DATA_W-1:0]   pwdata,
    output logic [adq_pkg::ADQ_APB_DATA_W-1:0]   prdata,
    output logic                                 pready
);
    import adq_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);

    // Configuration register: capacity_in_use.
    logic [ADQ_CAP_W-1:0] cap_reg;

    // Stage one holds the outcome of an accepted item while the store read completes.
    logic       st1_valid_reg;
    adq_rslt_t  st1_rslt_reg;
    logic       st1_adv;

    // Output register feeding the result channel.
    logic                       out_valid_reg;
    logic [ADQ_OUT_TDATA_W-1:0] out_tdata_reg;

    logic                  accept;
    logic                  wr_en, rd_en;
    logic [IW-1:0]         wr_addr, rd_addr;
    logic [ADQ_DATA_W-1:0] rd_data;
    logic [ADQ_DATA_W-1:0] removed;
    adq_rslt_t             rslt;

    // The register is written in the APB access phase; pready is tied high, so every
    // write completes without wait states. Writes beyond the register list are ignored.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= ADQ_CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == ADQ_REG_CAPACITY)) begin
            cap_reg <= pwdata[ADQ_CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ADQ_REG_CAPACITY)
                    ? {{(ADQ_APB_DATA_W-ADQ_CAP_W){1'b0}}, cap_reg}
                    : '0;

    // Stage one moves on whenever the output register is free or being drained,
    // so a new transfer is taken whenever stage one is empty or moving on.
    assign st1_adv  = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || st1_adv;
    assign accept   = s_tvalid && s_tready;

    adq_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cap_cfg (cap_reg),
        .accept  (accept),
        .op      (s_tdata[ADQ_OP_W-1:0]),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rslt    (rslt)
    );

    // Every accepted item reads the store and a push also writes it; a pop that
    // follows a push reads only after the write has landed.
    adq_ram #(
        .WIDTH (ADQ_DATA_W),
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata[ADQ_OP_W +: ADQ_DATA_W]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_rslt_reg <= rslt;
        end
    end

    // Only a successful pop reports the removed element; all else reports zero.
    assign removed = st1_rslt_reg.pop_ok ? rd_data : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            out_tdata_reg <= {1'b0, st1_rslt_reg.occupancy, removed, st1_rslt_reg.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

endmodule
